[hw/rtl/adcbi_pkg.sv]
// Shared types and constants of the four-channel ADC bus interface.
`timescale 1ns / 1ps

package adcbi_pkg;

    localparam int VOLT_W  = 16;
    localparam int TICK_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int QUO_W   = 12;
    localparam int DVD_W   = VOLT_W + QUO_W;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [TICK_W-1:0] TICKS_12_RESET = 16'd10000;
    localparam logic [TICK_W-1:0] TICKS_8_RESET  = 16'd4000;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_12 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_8  = 1'b1;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [1:0] ADDR_STATUS = 2'd0;
    localparam logic [1:0] ADDR_DATA_H = 2'd1;

    localparam int CR_WIDE_BIT = 3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

endpackage

[hw/rtl/adcbi_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module adcbi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [adcbi_pkg::DVD_W-1:0]   i_dividend,
    input  logic [adcbi_pkg::VOLT_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [adcbi_pkg::QUO_W-1:0]   o_quotient
);

    localparam int QW = adcbi_pkg::QUO_W;
    localparam int VW = adcbi_pkg::VOLT_W;
    localparam logic [adcbi_pkg::CNT_W-1:0] LAST_STEP = adcbi_pkg::CNT_W'(QW - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [adcbi_pkg::CNT_W-1:0] r_cnt;
    logic [VW-1:0]               r_rem;
    logic [VW-1:0]               r_div;
    logic [QW-1:0]               r_dvd;

    logic [VW:0] w_trial;
    logic [VW:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift line
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[adcbi_pkg::DVD_W-1:QW];
            r_dvd <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
            r_dvd <= {r_dvd[QW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without running");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < r_div)
        else $error("divider remainder out of range");
`endif

endmodule

[hw/rtl/four_channel_adc_bus_interface_top.sv]
// Top level of the four-channel ADC bus interface.
//
// Input channel (i_in_valid / o_in_ready) carries one item: a tick, a bus
// read or a bus write, with the four channel levels and the reference.
// Output channel (o_out_valid / i_out_ready) returns one item per input
// item: the read byte (zero for ticks and writes) and the active-low
// end-of-conversion pin after that item.
// Ticks, reads and writes are registered and show the cycle after
// acceptance. A tick that completes a conversion with a nonzero reference
// runs the 12-step bit-serial divider, and its result shows once the
// divider is done; with a zero reference it shows like any other item.
// A new item is taken outside division when the output register is empty
// or being read; with a free receiver, ordinary items flow at one per cycle.
// A stalled receiver holds the output item and blocks further input.
// Reset (synchronous, active low) restores the tick counts to 10000 and
// 4000, status 0x40, data registers zero and the pin high.
// The configuration port writes a tick count directly, with no handshake.
`timescale 1ns / 1ps

module four_channel_adc_bus_interface_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [adcbi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [adcbi_pkg::TICK_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [1:0]                        i_reg_addr,
    input  logic [adcbi_pkg::BYTE_W-1:0]      i_write_byte,
    input  logic [adcbi_pkg::VOLT_W-1:0]      i_volt_ch0,
    input  logic [adcbi_pkg::VOLT_W-1:0]      i_volt_ch1,
    input  logic [adcbi_pkg::VOLT_W-1:0]      i_volt_ch2,
    input  logic [adcbi_pkg::VOLT_W-1:0]      i_volt_ch3,
    input  logic [adcbi_pkg::VOLT_W-1:0]      i_ref_level,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [adcbi_pkg::BYTE_W-1:0]      o_read_byte,
    output logic                              o_eoc_pin_n
);

    localparam int VW = adcbi_pkg::VOLT_W;
    localparam int TW = adcbi_pkg::TICK_W;
    localparam int BW = adcbi_pkg::BYTE_W;
    localparam int DW = adcbi_pkg::DVD_W;
    localparam int QW = adcbi_pkg::QUO_W;

    adcbi_pkg::t_state r_state;

    logic [TW-1:0] r_ticks_12;
    logic [TW-1:0] r_ticks_8;
    logic [TW-1:0] r_latched;
    logic [TW-1:0] r_elapsed;
    logic          r_converting;
    logic [1:0]    r_ch;
    logic          r_wide;
    logic          r_eoc_bit;
    logic          r_notbusy;
    logic [1:0]    r_st_ch;
    logic          r_eoc_n;
    logic [BW-1:0] r_data_h;
    logic [BW-1:0] r_data_l;

    logic          r_out_valid;
    logic [BW-1:0] r_read_byte;
    logic          r_eoc_out;

    logic          w_accept;
    logic          w_complete;
    logic [VW-1:0] w_sel;
    logic [VW-1:0] w_v;
    logic [DW-1:0] w_prod;
    logic          w_div_start;
    logic          w_div_done;
    logic [QW-1:0] w_quo;
    logic [BW-1:0] w_status;
    logic [BW-1:0] w_rbyte;

    assign o_in_ready = (r_state == adcbi_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_complete = (i_cmd == adcbi_pkg::CMD_TICK) && r_converting
                        && (r_elapsed >= r_latched);
    assign w_status   = {r_eoc_bit, r_notbusy, 4'b0000, r_st_ch};

    always_comb begin
        case (r_ch)
            2'd0:    w_sel = i_volt_ch0;
            2'd1:    w_sel = i_volt_ch1;
            2'd2:    w_sel = i_volt_ch2;
            default: w_sel = i_volt_ch3;
        endcase
    end

    assign w_v = (w_sel > i_ref_level) ? i_ref_level : w_sel;

    // v * 0xfff or v * 0xff as shift and subtract
    assign w_prod = r_wide ? ({w_v, 12'b0} - {12'b0, w_v})
                           : ({4'b0, w_v, 8'b0} - {12'b0, w_v});

    assign w_div_start = w_accept && w_complete && (i_ref_level != '0);

    always_comb begin
        case (i_reg_addr)
            adcbi_pkg::ADDR_STATUS: w_rbyte = w_status;
            adcbi_pkg::ADDR_DATA_H: w_rbyte = r_data_h;
            default:                w_rbyte = r_data_l;
        endcase
    end

    adcbi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (i_ref_level),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_12 <= adcbi_pkg::TICKS_12_RESET;
            r_ticks_8  <= adcbi_pkg::TICKS_8_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adcbi_pkg::REG_TICKS_12: r_ticks_12 <= i_cfg_data;
                adcbi_pkg::REG_TICKS_8:  r_ticks_8  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= adcbi_pkg::ST_IDLE;
            r_latched    <= '0;
            r_elapsed    <= '0;
            r_converting <= 1'b0;
            r_ch         <= '0;
            r_wide       <= 1'b0;
            r_eoc_bit    <= 1'b0;
            r_notbusy    <= 1'b1;
            r_st_ch      <= '0;
            r_eoc_n      <= 1'b1;
            r_data_h     <= '0;
            r_data_l     <= '0;
            r_out_valid  <= 1'b0;
            r_read_byte  <= '0;
            r_eoc_out    <= 1'b1;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                adcbi_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_read_byte <= '0;
                        r_eoc_out   <= r_eoc_n;
                        r_out_valid <= 1'b1;
                        case (i_cmd)
                            adcbi_pkg::CMD_TICK: begin
                                if (w_complete) begin
                                    if (i_ref_level == '0) begin
                                        r_data_h     <= '0;
                                        r_data_l     <= '0;
                                        r_converting <= 1'b0;
                                        r_eoc_bit    <= 1'b1;
                                        r_notbusy    <= 1'b1;
                                        r_eoc_n      <= 1'b0;
                                        r_eoc_out    <= 1'b0;
                                    end else begin
                                        r_out_valid <= 1'b0;
                                        r_state     <= adcbi_pkg::ST_DIV;
                                    end
                                end else if (r_converting) begin
                                    r_elapsed <= r_elapsed + 1'b1;
                                end
                            end
                            adcbi_pkg::CMD_READ: begin
                                r_read_byte <= w_rbyte;
                                if (i_reg_addr == adcbi_pkg::ADDR_DATA_H) begin
                                    r_eoc_bit <= 1'b0;
                                    r_eoc_n   <= 1'b1;
                                    r_eoc_out <= 1'b1;
                                end
                            end
                            adcbi_pkg::CMD_WRITE: begin
                                if (i_reg_addr == adcbi_pkg::ADDR_STATUS) begin
                                    r_ch         <= i_write_byte[1:0];
                                    r_wide       <= i_write_byte[adcbi_pkg::CR_WIDE_BIT];
                                    r_converting <= 1'b1;
                                    r_elapsed    <= '0;
                                    r_latched    <= i_write_byte[adcbi_pkg::CR_WIDE_BIT]
                                                    ? r_ticks_12 : r_ticks_8;
                                    r_notbusy    <= 1'b0;
                                    r_st_ch      <= i_write_byte[1:0];
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                adcbi_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        if (r_wide) begin
                            r_data_h <= w_quo[QW-1:4];
                            r_data_l <= {w_quo[3:0], 4'b0000};
                        end else begin
                            r_data_h <= w_quo[BW-1:0];
                            r_data_l <= '0;
                        end
                        r_converting <= 1'b0;
                        r_eoc_bit    <= 1'b1;
                        r_notbusy    <= 1'b1;
                        r_eoc_n      <= 1'b0;
                        r_read_byte  <= '0;
                        r_eoc_out    <= 1'b0;
                        r_out_valid  <= 1'b1;
                        r_state      <= adcbi_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= adcbi_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_read_byte;
    assign o_eoc_pin_n = r_eoc_out;

`ifndef SYNTHESIS
    a_div_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == adcbi_pkg::ST_DIV |-> !o_in_ready)
        else $error("item taken during division");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == adcbi_pkg::ST_DIV)
        else $error("divider result outside division state");
    a_busy_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_converting != r_notbusy)
        else $error("not-busy bit disagrees with conversion state");
    a_pin_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eoc_n == !r_eoc_bit)
        else $error("end-of-conversion pin disagrees with status");
    a_div_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == adcbi_pkg::ST_DIV |-> !r_out_valid)
        else $error("output busy during division");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the four-channel ADC bus interface top level.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CMD_NONE     = 2'd3;
    localparam logic [1:0] ADDR_CONTROL = 2'd0;
    localparam logic [1:0] ADDR_DATA_L  = 2'd2;
    localparam logic [1:0] ADDR_DATA_L3 = 2'd3;
    localparam logic [7:0] SR_EOC       = 8'h80;
    localparam logic [7:0] SR_NOTBUSY   = 8'h40;
    localparam logic [31:0] RANGE_12    = 32'hfff;
    localparam logic [31:0] RANGE_8     = 32'hff;
    localparam logic [15:0] FULL        = 16'hffff;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  addr;
        logic [7:0]  wbyte;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] v2;
        logic [15:0] v3;
        logic [15:0] vref;
        logic        fixed;
        logic [7:0]  fixed_byte;
        logic        fixed_eoc;
    } t_adc_access;

    typedef struct packed {
        logic [7:0] rbyte;
        logic       eoc_n;
    } t_adc_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [adcbi_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [adcbi_pkg::TICK_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic o_out_valid;
    logic i_out_ready;
    logic [adcbi_pkg::BYTE_W-1:0] o_read_byte;
    logic o_eoc_pin_n;
    t_adc_access drv;

    four_channel_adc_bus_interface_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (drv.cmd),
        .i_reg_addr   (drv.addr),
        .i_write_byte (drv.wbyte),
        .i_volt_ch0   (drv.v0),
        .i_volt_ch1   (drv.v1),
        .i_volt_ch2   (drv.v2),
        .i_volt_ch3   (drv.v3),
        .i_ref_level  (drv.vref),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_byte  (o_read_byte),
        .o_eoc_pin_n  (o_eoc_pin_n)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] m_ticks12, m_ticks8, m_elapsed, m_limit;
    logic [7:0]  m_ctrl, m_status, m_dhi, m_dlo;
    logic        m_busy, m_eoc_n;

    t_adc_reply  adc_replies[$];
    t_adc_access access_q[$];
    t_adc_reply  want;
    t_adc_reply  got;
    int          mismatches = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          hold_left = 0;

    task automatic predict_bus_reply(input t_adc_access a, output t_adc_reply r);
        logic [31:0] lvl, vr, q;
        logic        wide;
        r.rbyte = '0;
        case (a.cmd)
            adcbi_pkg::CMD_TICK: begin
                if (m_busy) begin
                    if (m_elapsed >= m_limit) begin
                        case (m_ctrl[1:0])
                            2'd0:    lvl = {16'd0, a.v0};
                            2'd1:    lvl = {16'd0, a.v1};
                            2'd2:    lvl = {16'd0, a.v2};
                            default: lvl = {16'd0, a.v3};
                        endcase
                        vr = {16'd0, a.vref};
                        if (lvl > vr) lvl = vr;
                        wide = m_ctrl[adcbi_pkg::CR_WIDE_BIT];
                        q = (vr == 0) ? 32'd0 : (lvl * (wide ? RANGE_12 : RANGE_8)) / vr;
                        if (wide) begin
                            m_dhi = q[11:4];
                            m_dlo = {q[3:0], 4'b0000};
                        end else begin
                            m_dhi = q[7:0];
                            m_dlo = 8'h00;
                        end
                        m_busy = 1'b0;
                        m_status = m_status | SR_EOC | SR_NOTBUSY;
                        m_eoc_n = 1'b0;
                    end else begin
                        m_elapsed = m_elapsed + 16'd1;
                    end
                end
            end
            adcbi_pkg::CMD_READ: begin
                case (a.addr)
                    adcbi_pkg::ADDR_STATUS: r.rbyte = m_status;
                    adcbi_pkg::ADDR_DATA_H: begin
                        r.rbyte = m_dhi;
                        m_status = m_status & ~SR_EOC;
                        m_eoc_n = 1'b1;
                    end
                    default: r.rbyte = m_dlo;
                endcase
            end
            adcbi_pkg::CMD_WRITE: begin
                if (a.addr == ADDR_CONTROL) begin
                    m_ctrl = a.wbyte;
                    m_busy = 1'b1;
                    m_elapsed = '0;
                    m_limit = a.wbyte[adcbi_pkg::CR_WIDE_BIT] ? m_ticks12 : m_ticks8;
                    m_status = {m_status[7], 1'b0, m_status[5:2], a.wbyte[1:0]};
                end
            end
            default: ;
        endcase
        r.eoc_n = m_eoc_n;
    endtask

    function automatic t_adc_access mk_row(input logic [1:0] cmd, input logic [1:0] addr,
                                           input logic [7:0] wb, input logic [15:0] lvl,
                                           input logic [15:0] vref, input logic fixed,
                                           input logic [7:0] rb, input logic eoc_n);
        t_adc_access a;
        a = '{cmd, addr, wb, lvl, lvl, lvl, lvl, vref, fixed, rb, eoc_n};
        return a;
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return FULL;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_ref();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return FULL;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_adc_access rand_row(input logic [1:0] cmd, input logic [1:0] addr,
                                             input logic [7:0] wb);
        t_adc_access a;
        a = '0;
        a.cmd = cmd;
        a.addr = addr;
        a.wbyte = wb;
        a.v0 = rand_level();
        a.v1 = rand_level();
        a.v2 = rand_level();
        a.v3 = rand_level();
        a.vref = rand_ref();
        return a;
    endfunction

    // well-formed conversions with random content, plus some noise
    task automatic build_random(input int n);
        int lat, nt, pick;
        logic [7:0] wb;
        access_q.delete();
        while (access_q.size() < n) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4))
                    access_q.push_back(rand_row(2'($urandom_range(0, 3)),
                                                2'($urandom_range(0, 3)),
                                                8'($urandom_range(0, 255))));
            end else begin
                wb = 8'($urandom_range(0, 255));
                access_q.push_back(rand_row(adcbi_pkg::CMD_WRITE, ADDR_CONTROL, wb));
                lat = wb[adcbi_pkg::CR_WIDE_BIT] ? int'(m_ticks12) : int'(m_ticks8);
                if (lat > 18)
                    nt = $urandom_range(0, 20);
                else if ($urandom_range(0, 3) == 0)
                    nt = $urandom_range(0, lat);
                else
                    nt = lat + 1 + $urandom_range(0, 1);
                repeat (nt) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 2)
                        access_q.push_back(rand_row(adcbi_pkg::CMD_READ,
                                                    2'($urandom_range(0, 3)), 8'h00));
                    else if (pick == 2)
                        access_q.push_back(rand_row(adcbi_pkg::CMD_WRITE, ADDR_CONTROL,
                                                    8'($urandom_range(0, 255))));
                    access_q.push_back(rand_row(adcbi_pkg::CMD_TICK, 2'($urandom_range(0, 3)),
                                                8'($urandom_range(0, 255))));
                end
                access_q.push_back(rand_row(adcbi_pkg::CMD_READ, adcbi_pkg::ADDR_STATUS,
                                            8'h00));
                access_q.push_back(rand_row(adcbi_pkg::CMD_READ,
                                            $urandom_range(0, 1) ? ADDR_DATA_L : ADDR_DATA_L3,
                                            8'h00));
                access_q.push_back(rand_row(adcbi_pkg::CMD_READ, adcbi_pkg::ADDR_DATA_H,
                                            8'h00));
                access_q.push_back(rand_row(adcbi_pkg::CMD_READ, adcbi_pkg::ADDR_STATUS,
                                            8'h00));
            end
        end
    endtask

    task automatic send_row(input t_adc_access a);
        while ($urandom_range(0, 99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        drv <= a;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (adc_replies.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic run_rows();
        while (access_q.size() != 0) send_row(access_q.pop_front());
        i_in_valid <= 1'b0;
        drain();
    endtask

    task automatic write_reg(input logic [adcbi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == adcbi_pkg::REG_TICKS_12)
            m_ticks12 = val;
        else
            m_ticks8 = val;
        @(posedge i_clk);
    endtask

    // accepted item: predict and queue its reply
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_bus_reply(drv, got);
            if (drv.fixed)
                adc_replies.push_back('{drv.fixed_byte, drv.fixed_eoc});
            else
                adc_replies.push_back(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (adc_replies.size() == 0) begin
                $error("reply with nothing expected: read_byte %0h eoc_pin_n %0b",
                       o_read_byte, o_eoc_pin_n);
                mismatches++;
            end else begin
                want = adc_replies.pop_front();
                if (o_read_byte !== want.rbyte) begin
                    $error("read_byte: expected %0h, actual %0h", want.rbyte, o_read_byte);
                    mismatches++;
                end
                if (o_eoc_pin_n !== want.eoc_n) begin
                    $error("eoc_pin_n: expected %0b, actual %0b", want.eoc_n, o_eoc_pin_n);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    initial begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        drv <= '0;
        m_ticks12 = adcbi_pkg::TICKS_12_RESET;
        m_ticks8 = adcbi_pkg::TICKS_8_RESET;
        m_ctrl = 8'h00;
        m_status = SR_NOTBUSY;
        m_dhi = 8'h00;
        m_dlo = 8'h00;
        m_busy = 1'b0;
        m_elapsed = '0;
        m_limit = '0;
        m_eoc_n = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle = 19;
        rcv_idle = 78;
        // reset state, ignored accesses, start and restart under reset timing
        access_q = '{
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'h40, 1'b1),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_DATA_H, 8'h00, FULL, FULL, 1'b1,
                   8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_READ,  ADDR_DATA_L,  8'h00, FULL, FULL, 1'b1, 8'h00, 1'b1),
            mk_row(CMD_NONE,             ADDR_DATA_L3, 8'hff, FULL, FULL, 1'b1, 8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_WRITE, adcbi_pkg::ADDR_DATA_H, 8'hff, FULL, FULL, 1'b1,
                   8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_WRITE, ADDR_CONTROL, 8'h0b, FULL, FULL, 1'b1, 8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'h03, 1'b1),
            mk_row(adcbi_pkg::CMD_TICK,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_WRITE, ADDR_CONTROL, 8'h02, FULL, FULL, 1'b1, 8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'h02, 1'b1),
            mk_row(adcbi_pkg::CMD_READ,  ADDR_DATA_L3, 8'h00, FULL, FULL, 1'b1, 8'h00, 1'b1)
        };
        run_rows();

        write_reg(adcbi_pkg::REG_TICKS_12, 16'd1);
        write_reg(adcbi_pkg::REG_TICKS_8, 16'd1);
        // full scale, zero reference, clamp above reference
        access_q = '{
            mk_row(adcbi_pkg::CMD_WRITE, ADDR_CONTROL, 8'h08, FULL, FULL, 1'b1, 8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_TICK,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_TICK,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'h00, 1'b0),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'hc0, 1'b0),
            mk_row(adcbi_pkg::CMD_READ,  ADDR_DATA_L,  8'h00, FULL, FULL, 1'b1, 8'hf0, 1'b0),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_DATA_H, 8'h00, FULL, FULL, 1'b1,
                   8'hff, 1'b1),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, FULL, 1'b1,
                   8'h40, 1'b1),
            mk_row(adcbi_pkg::CMD_WRITE, ADDR_CONTROL, 8'hf1, 16'h0, 16'h0, 1'b1,
                   8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_TICK,  adcbi_pkg::ADDR_STATUS, 8'h00, 16'h1234, 16'h0, 1'b1,
                   8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_TICK,  adcbi_pkg::ADDR_STATUS, 8'h00, 16'h1234, 16'h0, 1'b1,
                   8'h00, 1'b0),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_DATA_H, 8'h00, 16'h0, 16'h0, 1'b1,
                   8'h00, 1'b1),
            mk_row(adcbi_pkg::CMD_WRITE, ADDR_CONTROL, 8'h0e, FULL, 16'h8000, 1'b0,
                   8'h00, 1'b0),
            mk_row(adcbi_pkg::CMD_TICK,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, 16'h8000, 1'b0,
                   8'h00, 1'b0),
            mk_row(adcbi_pkg::CMD_TICK,  adcbi_pkg::ADDR_STATUS, 8'h00, FULL, 16'h8000, 1'b0,
                   8'h00, 1'b0),
            mk_row(adcbi_pkg::CMD_READ,  ADDR_DATA_L3, 8'h00, FULL, 16'h8000, 1'b0,
                   8'h00, 1'b0),
            mk_row(adcbi_pkg::CMD_READ,  adcbi_pkg::ADDR_DATA_H, 8'h00, FULL, 16'h8000, 1'b0,
                   8'h00, 1'b0)
        };
        run_rows();

        build_random(200);
        run_rows();

        snd_idle = 78;
        rcv_idle = 19;
        write_reg(adcbi_pkg::REG_TICKS_12, 16'($urandom_range(2, 12)));
        write_reg(adcbi_pkg::REG_TICKS_8, 16'($urandom_range(2, 12)));
        build_random(200);
        run_rows();

        // longest conversion time: conversions are started and restarted but never complete
        snd_idle = 0;
        rcv_idle = 0;
        write_reg(adcbi_pkg::REG_TICKS_12, 16'hffff);
        write_reg(adcbi_pkg::REG_TICKS_8, 16'hffff);
        build_random(80);
        run_rows();

        write_reg(adcbi_pkg::REG_TICKS_12, 16'($urandom_range(1, 6)));
        write_reg(adcbi_pkg::REG_TICKS_8, 16'($urandom_range(1, 6)));
        build_random(150);
        hold_left = 300;
        run_rows();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hw/rtl/adcbi_pkg.sv
hw/rtl/adcbi_div.sv
hw/rtl/four_channel_adc_bus_interface_top.sv
tb/sv/testbench.sv
